[sv/tblp_pkg.sv]
// Shared types, constants and address helper for the tiled bitmap line plotter.
package tblp_pkg;

  localparam int MEMORY_WORDS_DEF = 2048;
  localparam logic [7:0] BITMAP_WIDTH_RESET = 8'd160;
  localparam int PIX_ADDR_W = 13;

  typedef enum logic [1:0] {
    OP_PLOT = 2'd0,
    OP_LINE = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  x_start;
    logic [7:0]  y_start;
    logic [7:0]  x_end;
    logic [7:0]  y_end;
    logic [1:0]  colour;
    logic [10:0] word_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [8:0]  pixels_plotted;
    logic        dropped;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [7:0] x;
    logic [7:0] y;
  } pix_t;

  // Word index of pixel (x, y): tile number times eight plus tile row.
  function automatic logic [PIX_ADDR_W-1:0] pixel_word(input logic [7:0] x,
                                                       input logic [7:0] y,
                                                       input logic [7:0] width);
    logic [9:0] prod;
    logic [9:0] tile;
    prod = 10'(y[7:3]) * 10'(width[7:3]);
    tile = prod + 10'(x[7:3]);
    return {tile, y[2:0]};
  endfunction

endpackage

[sv/tblp_stepper.sv]
// Midpoint line stepper: emits one pixel coordinate per cycle from start to end.
module tblp_stepper
  import tblp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       single,
  input  logic [7:0] x_start,
  input  logic [7:0] y_start,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  output pix_t       pix
);

  logic       active;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] acc;
  logic [7:0] den;
  logic [7:0] add;
  logic [7:0] remaining;
  logic       major_x;
  logic       x_neg;
  logic       y_neg;

  logic [7:0] dx;
  logic [7:0] dy;
  logic       major_x_in;
  logic [7:0] den_in;
  logic [7:0] add_in;
  logic [8:0] acc_sum;
  logic       minor;
  logic [7:0] acc_next;
  logic [7:0] x_inc;
  logic [7:0] y_inc;
  logic [7:0] x_next;
  logic [7:0] y_next;

  always_comb begin
    dx = (x_end > x_start) ? x_end - x_start : x_start - x_end;
    dy = (y_end > y_start) ? y_end - y_start : y_start - y_end;
    major_x_in = (dx >= dy);
    den_in = major_x_in ? dx : dy;
    add_in = major_x_in ? dy : dx;
  end

  always_comb begin
    acc_sum = {1'b0, acc} + {1'b0, add};
    minor = (acc_sum >= {1'b0, den});
    // after the subtract the accumulator stays below den
    acc_next = minor ? 8'(acc_sum - {1'b0, den}) : acc_sum[7:0];
    x_inc = x_neg ? 8'hFF : 8'h01;
    y_inc = y_neg ? 8'hFF : 8'h01;
    x_next = (major_x || minor) ? x + x_inc : x;
    y_next = (!major_x || minor) ? y + y_inc : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && remaining == 8'd0) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x         <= x_start;
      y         <= y_start;
      x_neg     <= (x_end < x_start);
      y_neg     <= (y_end < y_start);
      major_x   <= major_x_in;
      den       <= den_in;
      add       <= add_in;
      acc       <= {1'b0, den_in[7:1]};
      remaining <= single ? 8'd0 : den_in;
    end else if (active) begin
      x         <= x_next;
      y         <= y_next;
      acc       <= acc_next;
      remaining <= remaining - 8'd1;
    end
  end

  always_comb begin
    pix.valid = active;
    pix.last  = (remaining == 8'd0);
    pix.x     = x;
    pix.y     = y;
  end

endmodule

[sv/tiled_bitmap_line_plotter.sv]
// Plot and line: the stepper walks the pixels from start to end, one pixel per
// cycle through a read-modify-write pipeline on the tile memory (one read, one write port).
// Read word passes a read and a wait state; no operation goes straight to the result.
// The next item is taken once the result sits in the output register, even while it still
// waits to be taken. After reset a clearing pass writes zero to every word, during which
// no item is accepted; bitmap_width resets to 160.
module tiled_bitmap_line_plotter
  import tblp_pkg::*;
#(
  parameter int MEMORY_WORDS = MEMORY_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_write,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(MEMORY_WORDS);
  localparam logic [16:0] MEM_LIMIT = 17'(MEMORY_WORDS);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(MEMORY_WORDS - 1);

  logic [15:0] mem [MEMORY_WORDS];

  state_t state;
  state_t state_next;

  logic [7:0]    bitmap_width;
  logic [AW-1:0] clr_cnt;

  logic [1:0]    item_colour;
  logic [AW-1:0] item_idx;
  logic          item_rd_ok;

  logic [15:0]   res_rdata;
  logic [8:0]    count;
  logic          drop;

  logic          accept;
  logic          step_start;
  logic          done_load;
  pix_t          pix;

  logic [PIX_ADDR_W-1:0]    a_word;
  logic                     a_in_range;
  logic [AW+PIX_ADDR_W-1:0] a_ext;
  logic [AW+10:0]           rd_ext;
  logic                     rd_in_range;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  logic          b_valid;
  logic [AW-1:0] b_addr;
  logic [2:0]    b_col;
  logic          last_wvalid;
  logic [AW-1:0] last_waddr;
  logic [15:0]   last_wdata;
  logic [15:0]   b_base;
  logic [15:0]   b_mask;
  logic [15:0]   b_bits;
  logic [15:0]   b_word;

  assign accept = in_valid && in_ready;

  tblp_stepper u_stepper (
    .clk     (clk),
    .rst     (rst),
    .start   (step_start),
    .single  (in_item.operation == OP_PLOT),
    .x_start (in_item.x_start),
    .y_start (in_item.y_start),
    .x_end   (in_item.x_end),
    .y_end   (in_item.y_end),
    .pix     (pix)
  );

  // Address stage: word index of the current pixel and its range check.
  always_comb begin
    a_word     = pixel_word(pix.x, pix.y, bitmap_width);
    a_in_range = ({4'd0, a_word} < MEM_LIMIT);
    a_ext      = {{AW{1'b0}}, a_word};
    rd_ext     = {{AW{1'b0}}, in_item.word_address};
    rd_in_range = ({6'd0, in_item.word_address} < MEM_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == CLEAR_LAST) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.operation)
            OP_PLOT, OP_LINE: state_next = ST_DRAW;
            OP_READ:          state_next = ST_READ;
            default:          state_next = ST_DONE;
          endcase
        end
      end
      ST_DRAW:  if (pix.valid && pix.last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_READ:  state_next = ST_RWAIT;
      ST_RWAIT: state_next = ST_DONE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == ST_IDLE);
    step_start = accept && (in_item.operation == OP_PLOT || in_item.operation == OP_LINE);
    done_load  = (state == ST_DONE) && (!out_valid || out_ready);
    rd_en      = 1'b0;
    rd_addr    = item_idx;
    unique case (state)
      ST_DRAW: begin
        rd_en   = pix.valid && a_in_range;
        rd_addr = a_ext[AW-1:0];
      end
      ST_READ: begin
        rd_en   = item_rd_ok;
        rd_addr = item_idx;
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = item_idx;
      end
    endcase
  end

  // Modify stage: take the word just written if it is the same one.
  always_comb begin
    b_base = (last_wvalid && last_waddr == b_addr) ? last_wdata : rd_data;
    b_mask = 16'hC000 >> {b_col, 1'b0};
    b_bits = {item_colour, 14'd0} >> {b_col, 1'b0};
    b_word = (b_base & ~b_mask) | b_bits;
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 16'd0;
    end else begin
      wr_en   = b_valid;
      wr_addr = b_addr;
      wr_data = b_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      bitmap_width <= BITMAP_WIDTH_RESET;
      b_valid      <= 1'b0;
      last_wvalid  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_write) bitmap_width <= cfg_data;
      b_valid     <= (state == ST_DRAW) && pix.valid && a_in_range;
      last_wvalid <= wr_en;
      if (done_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_addr     <= a_ext[AW-1:0];
    b_col      <= pix.x[2:0];
    last_waddr <= wr_addr;
    last_wdata <= wr_data;
    if (accept) begin
      item_colour <= in_item.colour;
      item_idx    <= rd_ext[AW-1:0];
      item_rd_ok  <= rd_in_range;
      res_rdata   <= 16'd0;
      count       <= 9'd0;
      drop        <= (in_item.operation == OP_READ) && !rd_in_range;
    end else begin
      if (state == ST_DRAW && pix.valid) begin
        if (a_in_range) begin
          count <= count + 9'd1;
        end else begin
          drop <= 1'b1;
        end
      end
      if (state == ST_RWAIT && item_rd_ok) res_rdata <= rd_data;
    end
    if (done_load) begin
      out_item.read_data      <= res_rdata;
      out_item.pixels_plotted <= count;
      out_item.dropped        <= drop;
    end
  end

endmodule
